[src/crq_pkg.sv]
`timescale 1ns / 1ps

package crq_pkg;

   // Fixed field widths of the request and result beats.
   localparam int ADDR_W   = 32;
   localparam int WORDS_W  = 16;
   localparam int SEQ_W    = 16;
   localparam int HANDLE_W = 32;
   localparam int KIND_W   = 2;

   // Item kinds carried on the request channel.
   typedef enum logic [KIND_W-1:0] {
      KIND_SUBMIT   = 2'd0,
      KIND_COMPLETE = 2'd1,
      KIND_QUERY    = 2'd2
   } kind_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_COLLECT
   } state_type;

   // Where the start fields of a result come from.
   typedef enum logic [1:0] {
      START_NONE,
      START_INPUT,
      START_MEMORY
   } start_sel_type;

   // One request beat.
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [ADDR_W-1:0]   dest_address;
      logic [ADDR_W-1:0]   src_address;
      logic [WORDS_W-1:0]  word_count;
      logic [HANDLE_W-1:0] query_handle;
   } req_item_type;

   // One result beat.
   typedef struct packed {
      logic [HANDLE_W-1:0] issued_handle;
      logic                start_valid;
      logic [ADDR_W-1:0]   start_dest;
      logic [ADDR_W-1:0]   start_src;
      logic [WORDS_W-1:0]  start_words;
      logic                query_done;
      logic                engine_busy;
   } rsp_item_type;

   // Stored copy request of one ring slot.
   typedef struct packed {
      logic [ADDR_W-1:0]  dest;
      logic [ADDR_W-1:0]  src;
      logic [WORDS_W-1:0] words;
   } entry_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;
      logic execute;
      logic load_out;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

[src/crq_channels.sv]
`timescale 1ns / 1ps

// Request channel: submit, completion event or handle query.
interface crq_req_if;
   import crq_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [ADDR_W-1:0]   dest_address;
   logic [ADDR_W-1:0]   src_address;
   logic [WORDS_W-1:0]  word_count;
   logic [HANDLE_W-1:0] query_handle;

   modport source (
      output valid, kind, dest_address, src_address, word_count, query_handle,
      input  ready
   );
   modport sink (
      input  valid, kind, dest_address, src_address, word_count, query_handle,
      output ready
   );
endinterface

// Result channel: one beat per request beat.
interface crq_rsp_if;
   import crq_pkg::*;

   logic                valid;
   logic                ready;
   logic [HANDLE_W-1:0] issued_handle;
   logic                start_valid;
   logic [ADDR_W-1:0]   start_dest;
   logic [ADDR_W-1:0]   start_src;
   logic [WORDS_W-1:0]  start_words;
   logic                query_done;
   logic                engine_busy;

   modport source (
      output valid, issued_handle, start_valid, start_dest, start_src, start_words,
             query_done, engine_busy,
      input  ready
   );
   modport sink (
      input  valid, issued_handle, start_valid, start_dest, start_src, start_words,
             query_done, engine_busy,
      output ready
   );
endinterface

[src/crq_ctrl.sv]
`timescale 1ns / 1ps

module crq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  crq_pkg::status_type status,
   output crq_pkg::cmd_type    cmd
);
   import crq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: capture a beat, execute it, then hand the result over.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_COLLECT;
         end
         ST_COLLECT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture  = 1'b0;
      cmd.execute  = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_COLLECT: begin
            cmd.load_out = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

[src/crq_dpath.sv]
`timescale 1ns / 1ps

module crq_dpath #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  crq_pkg::cmd_type      cmd,
   output crq_pkg::status_type   status,
   input  crq_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output crq_pkg::rsp_item_type rsp_item
);
   import crq_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [OCC_W-1:0] FULL_COUNT = OCC_W'(QUEUE_DEPTH);
   localparam logic [SEQ_W-1:0] SLOT_LIMIT = SEQ_W'(QUEUE_DEPTH);

   // Captured request beat.
   req_item_type in_ff;

   // Ring pointers, fill count, sequence counter, engine flag and per-slot done and valid bits.
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [IDX_W-1:0]       tail_ff, tail_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic [SEQ_W-1:0]       next_seq_ff, next_seq_in;
   logic                   busy_ff, busy_in;
   logic [QUEUE_DEPTH-1:0] done_ff, done_in;
   logic [QUEUE_DEPTH-1:0] seq_valid_ff, seq_valid_in;

   // Slot storage.
   entry_type        pay_mem [QUEUE_DEPTH];
   logic [SEQ_W-1:0] seq_mem [QUEUE_DEPTH];
   entry_type        pay_rd_ff;
   logic [SEQ_W-1:0] seq_rd_ff;
   logic             seq_rd_valid_ff;
   logic             done_rd_ff;

   // Execute results kept for the collect step.
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   start_sel_type       start_sel_ff, start_sel_in;
   logic                query_ok_ff, query_ok_in;

   // Output register.
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff, rsp_in;

   // Decoded request.
   logic             is_submit, is_complete, is_query;
   logic             submit_ok, complete_ok;
   logic [IDX_W-1:0] head_adv, tail_adv, query_idx;
   logic [SEQ_W-1:0] seq_plus, query_slot, query_seq, stored_seq;

   assign is_submit   = (in_ff.kind == KIND_SUBMIT);
   assign is_complete = (in_ff.kind == KIND_COMPLETE);
   assign is_query    = (in_ff.kind == KIND_QUERY);
   assign submit_ok   = is_submit && (in_ff.word_count != '0) && (occ_ff != FULL_COUNT);
   assign complete_ok = is_complete && busy_ff && (occ_ff != '0);

   assign head_adv = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign tail_adv = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
   assign seq_plus = next_seq_ff + 1'b1;

   assign query_slot = in_ff.query_handle[SEQ_W-1:0];
   assign query_seq  = in_ff.query_handle[HANDLE_W-1:SEQ_W];
   assign query_idx  = query_slot[IDX_W-1:0];

   // Capture the accepted beat.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_ff <= req_item;
      end
   end

   // State update of the execute step.
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      next_seq_in  = next_seq_ff;
      busy_in      = busy_ff;
      done_in      = done_ff;
      seq_valid_in = seq_valid_ff;
      handle_in    = '0;
      start_sel_in = START_NONE;
      query_ok_in  = is_query && (in_ff.query_handle != '0) && (query_slot < SLOT_LIMIT);
      if (submit_ok) begin
         handle_in             = {next_seq_ff, SEQ_W'(head_ff)};
         seq_valid_in[head_ff] = 1'b1;
         done_in[head_ff]      = 1'b0;
         next_seq_in           = (seq_plus == '0) ? SEQ_W'(1) : seq_plus;
         head_in               = head_adv;
         occ_in                = occ_ff + 1'b1;
         // An idle engine implies an empty ring, so the new entry is the oldest.
         if (!busy_ff) begin
            busy_in      = 1'b1;
            start_sel_in = START_INPUT;
         end
      end else if (complete_ok) begin
         done_in[tail_ff] = 1'b1;
         tail_in          = tail_adv;
         occ_in           = occ_ff - 1'b1;
         if (occ_ff == OCC_W'(1)) begin
            busy_in = 1'b0;
         end else begin
            start_sel_in = START_MEMORY;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         next_seq_ff  <= SEQ_W'(1);
         busy_ff      <= 1'b0;
         done_ff      <= '0;
         seq_valid_ff <= '0;
      end else if (cmd.execute) begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         next_seq_ff  <= next_seq_in;
         busy_ff      <= busy_in;
         done_ff      <= done_in;
         seq_valid_ff <= seq_valid_in;
      end
   end

   // Execute results.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         handle_ff    <= handle_in;
         start_sel_ff <= start_sel_in;
         query_ok_ff  <= query_ok_in;
      end
   end

   // Slot memories: write at the head, read the next oldest and the queried slot.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (submit_ok) begin
            pay_mem[head_ff] <= '{dest: in_ff.dest_address, src: in_ff.src_address,
                                  words: in_ff.word_count};
            seq_mem[head_ff] <= next_seq_ff;
         end
         pay_rd_ff       <= pay_mem[tail_adv];
         seq_rd_ff       <= seq_mem[query_idx];
         seq_rd_valid_ff <= seq_valid_ff[query_idx];
         done_rd_ff      <= done_ff[query_idx];
      end
   end

   // Compose the result beat.
   assign stored_seq = seq_rd_valid_ff ? seq_rd_ff : '0;

   always_comb begin
      rsp_in               = '0;
      rsp_in.issued_handle = handle_ff;
      rsp_in.engine_busy   = busy_ff;
      rsp_in.query_done    = query_ok_ff && (stored_seq == query_seq) && done_rd_ff;
      case (start_sel_ff)
         START_INPUT: begin
            rsp_in.start_valid = 1'b1;
            rsp_in.start_dest  = in_ff.dest_address;
            rsp_in.start_src   = in_ff.src_address;
            rsp_in.start_words = in_ff.word_count;
         end
         START_MEMORY: begin
            rsp_in.start_valid = 1'b1;
            rsp_in.start_dest  = pay_rd_ff.dest;
            rsp_in.start_src   = pay_rd_ff.src;
            rsp_in.start_words = pay_rd_ff.words;
         end
         default: begin
            rsp_in.start_valid = 1'b0;
         end
      endcase
   end

   // Output register and its valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item        = rsp_ff;

endmodule

[src/copy_request_queue_with_tagged_handles.sv]
// A result beat is registered in the output register; the controller walks capture,
// execute (ring update and registered slot read) and collect, which waits for a free
// output register, and takes no new request beat until the last one is collected.
// Reset (synchronous, active high) clears the ring pointers, fill count, busy flag,
// done and slot valid bits and sets the sequence counter to 1 at the next clock edge.
`timescale 1ns / 1ps

module copy_request_queue_with_tagged_handles #(
   parameter int QUEUE_DEPTH = 8
) (
   input logic       clock,
   input logic       reset,
   crq_req_if.sink   req_bus,
   crq_rsp_if.source rsp_bus
);
   import crq_pkg::*;

   cmd_type      cmd;
   status_type   status;
   req_item_type req_item;
   rsp_item_type rsp_item;
   logic         req_ready;
   logic         rsp_valid;

   // Pack the request beat.
   assign req_item.kind         = req_bus.kind;
   assign req_item.dest_address = req_bus.dest_address;
   assign req_item.src_address  = req_bus.src_address;
   assign req_item.word_count   = req_bus.word_count;
   assign req_item.query_handle = req_bus.query_handle;
   assign req_bus.ready         = req_ready;

   crq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   crq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_item  (rsp_item)
   );

   // Unpack the result beat.
   assign rsp_bus.valid         = rsp_valid;
   assign rsp_bus.issued_handle = rsp_item.issued_handle;
   assign rsp_bus.start_valid   = rsp_item.start_valid;
   assign rsp_bus.start_dest    = rsp_item.start_dest;
   assign rsp_bus.start_src     = rsp_item.start_src;
   assign rsp_bus.start_words   = rsp_item.start_words;
   assign rsp_bus.query_done    = rsp_item.query_done;
   assign rsp_bus.engine_busy   = rsp_item.engine_busy;

endmodule

[dv/copy_request_queue_with_tagged_handles_tb.sv]
`timescale 1ns / 1ps

module copy_request_queue_with_tagged_handles_tb;
   import crq_pkg::*;

   localparam int DEPTH = 8;
   localparam int SLOT_W = $clog2(DEPTH);
   // Kind code that the block must ignore.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int HISTORY_MAX = 32;

   typedef struct {
      req_item_type beat;
      bit           typed;
      rsp_item_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   crq_req_if req_ch ();
   crq_rsp_if rsp_ch ();

   copy_request_queue_with_tagged_handles #(
      .QUEUE_DEPTH(DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_ch),
      .rsp_bus(rsp_ch)
   );

   // Shadow copy of the ring, its pointers and the engine flag.
   logic [ADDR_W-1:0]  ring_dest [DEPTH];
   logic [ADDR_W-1:0]  ring_src  [DEPTH];
   logic [WORDS_W-1:0] ring_words[DEPTH];
   logic [SEQ_W-1:0]   ring_seq  [DEPTH];
   logic               ring_done [DEPTH];
   logic [SLOT_W-1:0]  wr_slot;
   logic [SLOT_W-1:0]  rd_slot;
   int                 fill;
   logic [SEQ_W-1:0]   seq_counter;
   logic               engine_on;

   rsp_item_type   pending_results[$];
   logic [31:0]    issued_handles[$];
   stim_row_type   directed_rows[$];

   int  error_count;
   int  send_idle_pct;
   int  recv_idle_pct;
   logic rsp_hold;
   bit  fill_mode;
   int  kinds_sent[4];
   int  results_checked;
   int  starts_seen;
   int  done_hits;
   int  rejects_seen;

   // Clock with a 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // One line per failure, and a count of them.
   task automatic note_failure(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         note_failure($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      end
   endtask

   // Start the oldest queued request, or drop the engine to idle.
   function automatic void start_oldest(inout rsp_item_type r);
      if (fill == 0) begin
         engine_on = 1'b0;
      end else begin
         engine_on     = 1'b1;
         r.start_valid = 1'b1;
         r.start_dest  = ring_dest[rd_slot];
         r.start_src   = ring_src[rd_slot];
         r.start_words = ring_words[rd_slot];
      end
   endfunction

   // Applies one request beat to the shadow ring and returns its result beat.
   function automatic rsp_item_type queue_step_result(input req_item_type beat);
      rsp_item_type     r;
      logic [SEQ_W-1:0] seq;
      logic [15:0]      qslot;
      r = '0;
      case (beat.kind)
         KIND_SUBMIT: begin
            if (beat.word_count != '0 && fill < DEPTH) begin
               seq                 = seq_counter;
               ring_dest[wr_slot]  = beat.dest_address;
               ring_src[wr_slot]   = beat.src_address;
               ring_words[wr_slot] = beat.word_count;
               ring_seq[wr_slot]   = seq;
               ring_done[wr_slot]  = 1'b0;
               seq_counter         = seq + 16'd1;
               if (seq_counter == '0) seq_counter = 16'd1;
               r.issued_handle     = {seq, 16'(wr_slot)};
               wr_slot             = (int'(wr_slot) == DEPTH - 1) ? '0 : wr_slot + 1'b1;
               fill++;
               if (!engine_on) start_oldest(r);
            end
         end
         KIND_COMPLETE: begin
            if (engine_on && fill != 0) begin
               ring_done[rd_slot] = 1'b1;
               rd_slot            = (int'(rd_slot) == DEPTH - 1) ? '0 : rd_slot + 1'b1;
               fill--;
               start_oldest(r);
            end
         end
         KIND_QUERY: begin
            qslot = beat.query_handle[15:0];
            if (beat.query_handle != '0 && int'(qslot) < DEPTH) begin
               if (ring_seq[qslot[SLOT_W-1:0]] == beat.query_handle[31:16]) begin
                  r.query_done = ring_done[qslot[SLOT_W-1:0]];
               end
            end
         end
         default: ;
      endcase
      r.engine_busy = engine_on;
      return r;
   endfunction

   // Random request: mostly well-formed traffic, steered to fill and drain the ring.
   function automatic req_item_type random_request();
      req_item_type beat;
      int           roll;
      int           submit_pct;
      int           complete_pct;
      beat.kind         = KIND_SUBMIT;
      beat.dest_address = $urandom;
      beat.src_address  = $urandom;
      beat.word_count   = 16'($urandom_range(65535, 1));
      beat.query_handle = $urandom;
      if (fill == DEPTH) fill_mode = 1'b0;
      if (fill == 0) fill_mode = 1'b1;
      submit_pct   = fill_mode ? 55 : 20;
      complete_pct = fill_mode ? 20 : 55;
      roll = $urandom_range(99);
      if (roll < submit_pct) begin
         if ($urandom_range(19) == 0) beat.word_count = '0;
      end else if (roll < submit_pct + complete_pct) begin
         beat.kind = KIND_COMPLETE;
      end else if (roll < 96) begin
         beat.kind = KIND_QUERY;
         roll = $urandom_range(99);
         if (issued_handles.size() != 0 && roll < 70) begin
            beat.query_handle =
               issued_handles[$urandom_range(issued_handles.size() - 1)];
         end else if (issued_handles.size() != 0 && roll < 85) begin
            // A stale or forged sequence on a real slot.
            beat.query_handle =
               issued_handles[$urandom_range(issued_handles.size() - 1)] ^
               (32'h1 << (16 + $urandom_range(15)));
         end else if (roll < 90) begin
            beat.query_handle = '0;
         end
      end else begin
         beat.kind = KIND_UNUSED;
      end
      return beat;
   endfunction

   // Offers one beat after a random gap; predicts its result once it is taken.
   task automatic send_beat(input req_item_type beat, input bit typed,
                            input rsp_item_type want);
      rsp_item_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= beat.kind;
      req_ch.dest_address <= beat.dest_address;
      req_ch.src_address  <= beat.src_address;
      req_ch.word_count   <= beat.word_count;
      req_ch.query_handle <= beat.query_handle;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = queue_step_result(beat);
      pending_results.push_back(typed ? want : predicted);
      kinds_sent[beat.kind]++;
      if (predicted.issued_handle != '0) begin
         issued_handles.push_back(predicted.issued_handle);
         if (issued_handles.size() > HISTORY_MAX) void'(issued_handles.pop_front());
      end
   endtask

   task automatic run_random(input int count, input int send_pct, input int recv_pct);
      rsp_item_type unused_want;
      unused_want   = '0;
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
      for (int i = 0; i < count; i++) begin
         // Every so often a stretch with no idling on the request side.
         if (i % 100 == 50) send_idle_pct = 0;
         if (i % 100 == 80) send_idle_pct = send_pct;
         send_beat(random_request(), 1'b0, unused_want);
      end
   endtask

   task automatic add_row(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] dest,
                          input logic [ADDR_W-1:0] src, input logic [WORDS_W-1:0] words,
                          input logic [HANDLE_W-1:0] handle, input bit typed,
                          input rsp_item_type want);
      stim_row_type row;
      row.beat.kind         = kind;
      row.beat.dest_address = dest;
      row.beat.src_address  = src;
      row.beat.word_count   = words;
      row.beat.query_handle = handle;
      row.typed             = typed;
      row.want              = want;
      directed_rows.push_back(row);
   endtask

   // Result side: compare each accepted beat with the oldest expectation.
   initial begin
      rsp_item_type want;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               note_failure("result beat with nothing expected");
            end else begin
               want = pending_results.pop_front();
               check_field("issued_handle", 64'(rsp_ch.issued_handle),
                           64'(want.issued_handle));
               check_field("start_valid", 64'(rsp_ch.start_valid), 64'(want.start_valid));
               check_field("start_dest", 64'(rsp_ch.start_dest), 64'(want.start_dest));
               check_field("start_src", 64'(rsp_ch.start_src), 64'(want.start_src));
               check_field("start_words", 64'(rsp_ch.start_words), 64'(want.start_words));
               check_field("query_done", 64'(rsp_ch.query_done), 64'(want.query_done));
               check_field("engine_busy", 64'(rsp_ch.engine_busy), 64'(want.engine_busy));
               results_checked++;
               if (want.start_valid) starts_seen++;
               if (want.query_done) done_hits++;
            end
         end
         rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Stimulus: directed table, then three idling phases with a long receiver stall.
   initial begin
      rsp_item_type zero_idle;
      rsp_item_type zero_busy;
      rsp_item_type w;

      req_ch.valid        = 1'b0;
      req_ch.kind         = KIND_SUBMIT;
      req_ch.dest_address = '0;
      req_ch.src_address  = '0;
      req_ch.word_count   = '0;
      req_ch.query_handle = '0;
      rsp_hold            = 1'b0;
      recv_idle_pct       = 0;
      send_idle_pct       = 0;
      error_count         = 0;
      fill_mode           = 1'b1;
      wr_slot             = '0;
      rd_slot             = '0;
      fill                = 0;
      seq_counter         = 16'd1;
      engine_on           = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         ring_dest[i]  = '0;
         ring_src[i]   = '0;
         ring_words[i] = '0;
         ring_seq[i]   = '0;
         ring_done[i]  = 1'b0;
      end

      zero_idle = '0;
      zero_busy = '0;
      zero_busy.engine_busy = 1'b1;

      // Idle block: query of handle zero, completion while idle, unknown kind,
      // zero word count.
      add_row(KIND_QUERY, '0, '0, '0, '0, 1'b1, zero_idle);
      add_row(KIND_COMPLETE, '1, '1, '1, '1, 1'b1, zero_idle);
      add_row(KIND_UNUSED, '1, '1, '1, '1, 1'b1, zero_idle);
      add_row(KIND_SUBMIT, '1, '1, '0, '1, 1'b1, zero_idle);
      // First submit starts at once; the second is queued behind it.
      w = zero_busy;
      w.issued_handle = 32'h0001_0000;
      w.start_valid   = 1'b1;
      w.start_dest    = '1;
      w.start_words   = '1;
      add_row(KIND_SUBMIT, '1, '0, '1, '0, 1'b1, w);
      w = zero_busy;
      w.issued_handle = 32'h0002_0001;
      add_row(KIND_SUBMIT, '0, '1, 16'd1, '0, 1'b1, w);
      add_row(KIND_QUERY, '0, '0, '0, 32'h0001_0000, 1'b1, zero_busy);
      // Completion finishes slot 0 and starts slot 1.
      w = zero_busy;
      w.start_valid = 1'b1;
      w.start_src   = '1;
      w.start_words = 16'd1;
      add_row(KIND_COMPLETE, '0, '0, '0, '0, 1'b1, w);
      w = zero_busy;
      w.query_done = 1'b1;
      add_row(KIND_QUERY, '0, '0, '0, 32'h0001_0000, 1'b1, w);
      // Slot out of range, sequence mismatch, all ones.
      add_row(KIND_QUERY, '0, '0, '0, 32'h0001_0008, 1'b1, zero_busy);
      add_row(KIND_QUERY, '0, '0, '0, 32'h0001_FFFF, 1'b1, zero_busy);
      add_row(KIND_QUERY, '0, '0, '0, 32'h0005_0000, 1'b1, zero_busy);
      add_row(KIND_QUERY, '0, '0, '0, 32'hFFFF_FFFF, 1'b1, zero_busy);
      // Fill the ring; the next submit is turned away.
      for (int i = 0; i < DEPTH - 1; i++) begin
         add_row(KIND_SUBMIT, 32'hA5A5_0000 + i, 32'h5A5A_0000 + i, 16'(i + 2), '0,
                 1'b0, zero_idle);
      end
      add_row(KIND_SUBMIT, '1, '1, '1, '0, 1'b1, zero_busy);
      add_row(KIND_QUERY, '0, '0, '0, 32'h0003_0002, 1'b0, zero_idle);
      add_row(KIND_QUERY, '0, '0, '0, 32'h0009_0000, 1'b0, zero_idle);
      // Slot 0 was reused, so its first handle is stale now.
      add_row(KIND_QUERY, '0, '0, '0, 32'h0001_0000, 1'b1, zero_busy);
      add_row(KIND_COMPLETE, '0, '0, '0, '0, 1'b0, zero_idle);
      add_row(KIND_COMPLETE, '0, '0, '0, '0, 1'b0, zero_idle);

      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 8;
      recv_idle_pct <= 83;
      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
      end

      run_random(300, 8, 83);
      run_random(300, 83, 8);
      // Receiver holds off for a long stretch while requests keep coming.
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      run_random(300, 0, 0);

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d submits, %0d completions, %0d queries, %0d unknown kinds.",
               kinds_sent[KIND_SUBMIT], kinds_sent[KIND_COMPLETE],
               kinds_sent[KIND_QUERY], kinds_sent[KIND_UNUSED]);
      $display("Checked %0d result beats: %0d transfer starts, %0d finished handles.",
               results_checked, starts_seen, done_hits);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #(30_000_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule
